@@ rtl/core/ppfc_pkg.sv @@
// Shared constants, codes and the result beat layout of the ping-pong frame capture block.
package ppfc_pkg;

  localparam int MAX_FRAME   = 64;
  localparam int SAMPLE_BITS = 12;
  localparam int RING_DEPTH  = 2 * MAX_FRAME;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int LEN_W       = 7;
  localparam int CNT_W       = 32;

  localparam logic [LEN_W-1:0]       FRAME_LEN_RESET = 7'd32;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID      = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic [1:0]             BOTH_HALVES     = 2'b11;

  // Input item kinds carried on tuser.
  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_ACQUIRE = 2'd1;
  localparam logic [1:0] ACT_START   = 2'd2;
  localparam logic [1:0] ACT_STOP    = 2'd3;

  // Result beat payload, first member in the highest bits.
  typedef struct packed {
    logic [4:0]             pad;
    logic [LEN_W-1:0]       frame_samples_out;
    logic                   capturing;
    logic [SAMPLE_BITS-1:0] last_raw_value;
    logic [RING_AW-1:0]     write_position;
    logic [CNT_W-1:0]       dropped_count;
    logic                   overflow_flag;
    logic [1:0]             ready_bits;
    logic [CNT_W-1:0]       frame_number;
    logic                   half_index;
    logic [SAMPLE_BITS-1:0] centered_sample;
  } out_beat_t;

  localparam int OUT_W = $bits(out_beat_t);

endpackage

@@ rtl/core/ping_pong_frame_capture_top.sv @@
// Top level of the ping-pong frame capture block: sample ring, half tracking and frame readout.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser = action, tdata = raw_sample
// m_axis    out  m_axis_tvalid/tready      tuser = valid_res, tlast = last, tdata = status
// cfg       in   cfg_valid/cfg_ready       cfg_data = frame_length
//
// A sample, stop, or acquire with no half ready yields one beat.
// Start yields its beat at once, then sweeps the 128-entry ring to zero, one entry per
// cycle, so the block is not ready again until the sweep is done.
// Acquire of a ready half picks the half and reads the final sample, then yields one beat
// per cycle while the output is not stalled, for the effective frame length; the single
// ring read port sets that pace. Reset is synchronous and clears all control and status state.
// A stalled output holds the beat in place; the next input is taken once the output
// register is empty or draining in the same cycle.
module ping_pong_frame_capture_top
  import ppfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // [11:0] raw_sample, [15:12] zero
  input  logic [1:0]           s_axis_tuser,  // [1:0] action
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [11:0] centered_sample, [12] half_index, [44:13] frame_number, [46:45] ready_bits,
  // [47] overflow_flag, [79:48] dropped_count, [86:80] write_position,
  // [98:87] last_raw_value, [99] capturing, [106:100] frame_samples_out, [111:107] zero
  output logic [OUT_W-1:0]     m_axis_tdata,
  output logic [0:0]           m_axis_tuser,  // [0] valid_res
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LEN_W-1:0]     cfg_data       // [6:0] frame_length
);

  // Sequencer codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_LAST  = 2'd2;
  localparam logic [1:0] ST_BEAT  = 2'd3;

  logic [1:0]             state, state_next;
  logic [LEN_W-1:0]       frame_length;
  logic [RING_AW-1:0]     write_ptr, write_ptr_next;
  logic                   fill_half, fill_half_next;
  logic [1:0]             full_mask, full_mask_next;
  logic                   overflow_sticky, overflow_sticky_next;
  logic [CNT_W-1:0]       lost_frames, lost_frames_next;
  logic [CNT_W-1:0]       sequence_counter, sequence_counter_next;
  logic [CNT_W-1:0]       stamp0, stamp0_next;
  logic [CNT_W-1:0]       stamp1, stamp1_next;
  logic [SAMPLE_BITS-1:0] tail_raw, tail_raw_next;
  logic                   running, running_next;

  logic                   acq_half, acq_half_next;
  logic [LEN_W-1:0]       acq_len, acq_len_next;
  logic [RING_AW-1:0]     acq_base, acq_base_next;
  logic [CNT_W-1:0]       acq_stamp, acq_stamp_next;
  logic [LEN_W-1:0]       beat_idx, beat_idx_next;
  logic [RING_AW-1:0]     clr_idx, clr_idx_next;

  // The ring and its registered read port.
  logic [SAMPLE_BITS-1:0] sample_ring [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [RING_AW-1:0]     rd_base, rd_off, rd_addr;
  logic                   ring_we;
  logic [RING_AW-1:0]     ring_wa;
  logic [SAMPLE_BITS-1:0] ring_wd;

  // Output register.
  logic                   out_valid;
  out_beat_t              out_data;
  logic                   out_user, out_last;
  logic                   out_free, in_fire, load_out, load_beat;
  out_beat_t              beat_next;

  logic [1:0]             action;
  logic [SAMPLE_BITS-1:0] raw;
  logic [LEN_W-1:0]       len;
  logic [LEN_W:0]         ptr_inc, len2;
  logic [RING_AW-1:0]     ptr_wrap;
  logic                   cur_half, sel_half;

  assign action   = s_axis_tuser;
  assign raw      = s_axis_tdata[SAMPLE_BITS-1:0];
  assign out_free = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // Effective frame length: zero acts as one, anything above the ring half as a full half.
  always_comb begin
    if (frame_length == '0) begin
      len = LEN_W'(1);
    end else if (frame_length > LEN_W'(MAX_FRAME)) begin
      len = LEN_W'(MAX_FRAME);
    end else begin
      len = frame_length;
    end
  end

  // Write position advance; a position left beyond a shrunk ring still wraps to zero.
  assign ptr_inc  = {1'b0, write_ptr} + (LEN_W+1)'(1);
  assign len2     = {len, 1'b0};
  assign ptr_wrap = (ptr_inc >= len2) ? '0 : ptr_inc[RING_AW-1:0];
  assign cur_half = (ptr_wrap < len) ? 1'b0 : 1'b1;

  // Oldest ready half, half 0 on a tie.
  always_comb begin
    if (full_mask == BOTH_HALVES) begin
      sel_half = (stamp0 <= stamp1) ? 1'b0 : 1'b1;
    end else begin
      sel_half = !full_mask[0];
    end
  end

  // Shared address adder for every ring read.
  assign rd_addr = rd_base + rd_off;

  always_comb begin
    state_next            = state;
    write_ptr_next        = write_ptr;
    fill_half_next        = fill_half;
    full_mask_next        = full_mask;
    overflow_sticky_next  = overflow_sticky;
    lost_frames_next      = lost_frames;
    sequence_counter_next = sequence_counter;
    stamp0_next           = stamp0;
    stamp1_next           = stamp1;
    tail_raw_next         = tail_raw;
    running_next          = running;
    acq_half_next         = acq_half;
    acq_len_next          = acq_len;
    acq_base_next         = acq_base;
    acq_stamp_next        = acq_stamp;
    beat_idx_next         = beat_idx;
    clr_idx_next          = clr_idx;
    ring_we               = 1'b0;
    ring_wa               = write_ptr;
    ring_wd               = raw;
    rd_base               = acq_base;
    rd_off                = beat_idx[RING_AW-1:0];
    load_out              = 1'b0;
    load_beat             = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (action)
            ACT_SAMPLE: begin
              load_out = 1'b1;
              if (running) begin
                ring_we        = 1'b1;
                write_ptr_next = ptr_wrap;
                if (cur_half != fill_half) begin
                  if (full_mask[fill_half]) begin
                    overflow_sticky_next = 1'b1;
                    lost_frames_next     = lost_frames + CNT_W'(1);
                  end
                  sequence_counter_next = sequence_counter + CNT_W'(1);
                  if (fill_half) begin
                    stamp1_next = sequence_counter + CNT_W'(1);
                  end else begin
                    stamp0_next = sequence_counter + CNT_W'(1);
                  end
                  full_mask_next = full_mask | (fill_half ? 2'b10 : 2'b01);
                  fill_half_next = cur_half;
                end
              end
            end
            ACT_START: begin
              load_out              = 1'b1;
              stamp0_next           = '0;
              stamp1_next           = '0;
              running_next          = 1'b1;
              overflow_sticky_next  = 1'b0;
              full_mask_next        = '0;
              write_ptr_next        = '0;
              fill_half_next        = 1'b0;
              sequence_counter_next = '0;
              lost_frames_next      = '0;
              tail_raw_next         = '0;
              clr_idx_next          = '0;
              state_next            = ST_CLEAR;
            end
            ACT_STOP: begin
              load_out     = 1'b1;
              running_next = 1'b0;
            end
            ACT_ACQUIRE: begin
              if (full_mask == '0) begin
                load_out = 1'b1;
              end else begin
                acq_half_next  = sel_half;
                acq_len_next   = len;
                acq_base_next  = sel_half ? len[RING_AW-1:0] : '0;
                acq_stamp_next = sel_half ? stamp1 : stamp0;
                full_mask_next = full_mask & (sel_half ? 2'b01 : 2'b10);
                // Fetch the final sample first: every beat shows it as last_raw_value.
                rd_base    = sel_half ? len[RING_AW-1:0] : '0;
                rd_off     = RING_AW'(len - LEN_W'(1));
                state_next = ST_LAST;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        ring_we      = 1'b1;
        ring_wa      = clr_idx;
        ring_wd      = '0;
        clr_idx_next = clr_idx + RING_AW'(1);
        if (clr_idx == RING_AW'(RING_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_LAST: begin
        tail_raw_next = rd_data;
        beat_idx_next = '0;
        rd_off        = '0;
        state_next    = ST_BEAT;
      end
      ST_BEAT: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_beat = 1'b1;
          rd_off    = beat_idx[RING_AW-1:0] + RING_AW'(1);
          if (beat_idx == acq_len - LEN_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            beat_idx_next = beat_idx + LEN_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Beat contents: status always shows the state after the item.
  always_comb begin
    beat_next                   = '0;
    beat_next.ready_bits        = full_mask_next;
    beat_next.overflow_flag     = overflow_sticky_next;
    beat_next.dropped_count     = lost_frames_next;
    beat_next.write_position    = write_ptr_next;
    beat_next.last_raw_value    = tail_raw_next;
    beat_next.capturing         = running_next;
    if (load_beat) begin
      beat_next.centered_sample   = rd_data - SAMPLE_MID;
      beat_next.half_index        = acq_half;
      beat_next.frame_number      = acq_stamp;
      beat_next.frame_samples_out = acq_len;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      sample_ring[ring_wa] <= ring_wd;
    end
    rd_data <= sample_ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      frame_length     <= FRAME_LEN_RESET;
      write_ptr        <= '0;
      fill_half        <= 1'b0;
      full_mask        <= '0;
      overflow_sticky  <= 1'b0;
      lost_frames      <= '0;
      sequence_counter <= '0;
      stamp0           <= '0;
      stamp1           <= '0;
      tail_raw         <= '0;
      running          <= 1'b0;
      beat_idx         <= '0;
      clr_idx          <= '0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      write_ptr        <= write_ptr_next;
      fill_half        <= fill_half_next;
      full_mask        <= full_mask_next;
      overflow_sticky  <= overflow_sticky_next;
      lost_frames      <= lost_frames_next;
      sequence_counter <= sequence_counter_next;
      stamp0           <= stamp0_next;
      stamp1           <= stamp1_next;
      tail_raw         <= tail_raw_next;
      running          <= running_next;
      beat_idx         <= beat_idx_next;
      clr_idx          <= clr_idx_next;
      if (cfg_valid && cfg_ready) begin
        frame_length <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Acquisition context and output payload need no reset.
  always_ff @(posedge clk) begin
    acq_half  <= acq_half_next;
    acq_len   <= acq_len_next;
    acq_base  <= acq_base_next;
    acq_stamp <= acq_stamp_next;
    if (load_out) begin
      out_data <= beat_next;
      out_user <= load_beat;
      out_last <= !load_beat || (beat_idx == acq_len - LEN_W'(1));
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_user;
  assign m_axis_tlast    = out_last;

  // An acquire that finds a ready half always goes on to fetch the final sample.
  a_acq_fetch : assert property (@(posedge clk) disable iff (rst)
    (in_fire && action == ACT_ACQUIRE && full_mask != '0) |=> (state == ST_LAST))
    else $error("acquire of a ready half did not start the readout");

  // A status beat is always a run of one.
  a_status_single : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("status beat without tlast");

  // A stalled frame beat freezes the readout position.
  a_beat_hold : assert property (@(posedge clk) disable iff (rst)
    (state == ST_BEAT && !out_free) |=> (state == ST_BEAT && $stable(beat_idx)))
    else $error("readout advanced while the output was stalled");

  // The overflow flag only rises together with a dropped frame.
  a_overflow_count : assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_sticky) |-> (lost_frames != $past(lost_frames)))
    else $error("overflow set without counting a dropped frame");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the ping-pong frame capture block: stream stimulus and beat checks.
module tb
  import ppfc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One pending input beat: the action and the converter value that goes with it.
  typedef struct {
    logic [1:0]  act;
    logic [11:0] raw;
  } stim_item_t;

  // One predicted output beat: the two sideband fields plus the packed status payload.
  typedef struct {
    logic      valid_res;
    logic      last;
    out_beat_t f;
  } capture_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;   // [11:0] raw_sample, [15:12] zero
  logic [1:0]          s_axis_tuser = '0;   // [1:0] action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;        // packed out_beat_t, centered_sample lowest
  logic [0:0]          m_axis_tuser;        // [0] valid_res
  logic                m_axis_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_data = '0;       // [6:0] frame_length

  ping_pong_frame_capture_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Beats waiting to be driven, and the beats the block is expected to send back.
  stim_item_t    pending_items[$];
  capture_beat_t expected_beats[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned item_count = 0;
  logic        gen_running = 1'b0;   // generator's view of capture state, for counting
  logic        in_taken = 1'b0;      // the driven input beat was accepted at the last edge
  stim_item_t  drive_item;

  // Shadow copy of the capture state. Initial values match the reset state, and reset is
  // applied only once at the start, so no separate reset of the shadow is needed.
  logic [11:0]      ring_img [RING_DEPTH];
  logic [6:0]       wr_pos = '0;
  logic             cur_half = 1'b0;
  logic [1:0]       ready_set = '0;
  logic             ovf = 1'b0;
  logic [31:0]      drop_cnt = '0;
  logic [31:0]      seq_cnt = '0;
  logic [31:0]      stamp [2] = '{32'd0, 32'd0};
  logic [11:0]      tail_raw_q = '0;
  logic             run = 1'b0;
  logic [LEN_W-1:0] flen = FRAME_LEN_RESET;

  // A register value of zero behaves as one sample per half, anything above the ring
  // limit behaves as the largest frame.
  function automatic int unsigned eff_len(input logic [LEN_W-1:0] v);
    int unsigned n;
    n = v;
    if (n == 0) n = 1;
    if (n > MAX_FRAME) n = MAX_FRAME;
    return n;
  endfunction

  // Queue one expected beat; the status fields always show the state after the item.
  function automatic void expect_beat(input logic vld, input logic [11:0] cen,
                                      input logic hf, input logic [31:0] num,
                                      input logic lst, input logic [6:0] cnt);
    capture_beat_t e;
    e.valid_res           = vld;
    e.last                = lst;
    e.f                   = '0;
    e.f.centered_sample   = cen;
    e.f.half_index        = hf;
    e.f.frame_number      = num;
    e.f.ready_bits        = ready_set;
    e.f.overflow_flag     = ovf;
    e.f.dropped_count     = drop_cnt;
    e.f.write_position    = wr_pos;
    e.f.last_raw_value    = tail_raw_q;
    e.f.capturing         = run;
    e.f.frame_samples_out = cnt;
    expected_beats.push_back(e);
  endfunction

  // Advance the shadow state by one accepted input beat and queue the beats it causes.
  task automatic predict_capture(input logic [1:0] act, input logic [11:0] raw);
    int unsigned len, base, nxt, k;
    logic        h, nh;
    logic [11:0] v;
    len = eff_len(flen);
    case (act)
      ACT_SAMPLE: begin
        if (run) begin
          ring_img[wr_pos] = raw;
          // The position may sit past the ring after a shrink; it still wraps to zero.
          nxt = wr_pos + 1;
          if (nxt >= 2 * len) nxt = 0;
          wr_pos = 7'(nxt);
          nh = (wr_pos < len) ? 1'b0 : 1'b1;
          if (nh != cur_half) begin
            if (ready_set[cur_half]) begin
              ovf      = 1'b1;
              drop_cnt = drop_cnt + 1;
            end
            seq_cnt             = seq_cnt + 1;
            stamp[cur_half]     = seq_cnt;
            ready_set[cur_half] = 1'b1;
            cur_half            = nh;
          end
        end
      end
      ACT_START: begin
        for (k = 0; k < RING_DEPTH; k++) ring_img[k] = '0;
        stamp[0]   = '0;
        stamp[1]   = '0;
        run        = 1'b1;
        ovf        = 1'b0;
        ready_set  = '0;
        wr_pos     = '0;
        cur_half   = 1'b0;
        seq_cnt    = '0;
        drop_cnt   = '0;
        tail_raw_q = '0;
      end
      ACT_STOP: run = 1'b0;
      default: begin
        if (ready_set != 2'b00) begin
          // The older half goes first; with both ready, a tie favors half zero.
          if (ready_set == BOTH_HALVES) h = (stamp[0] <= stamp[1]) ? 1'b0 : 1'b1;
          else h = ready_set[0] ? 1'b0 : 1'b1;
          base         = h * len;
          tail_raw_q   = ring_img[7'(base + len - 1)];
          ready_set[h] = 1'b0;
          for (k = 0; k < len; k++) begin
            v = ring_img[7'(base + k)];
            expect_beat(1'b1, v - SAMPLE_MID, h, stamp[h], k + 1 == len, 7'(len));
          end
          return;
        end
      end
    endcase
    expect_beat(1'b0, '0, 1'b0, '0, 1'b1, '0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Output monitor first, then input capture: an output beat can never stem from an
  // input accepted at the same edge, so checking before predicting is safe.
  always @(posedge clk) begin : monitor
    capture_beat_t e;
    out_beat_t     got;
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          e = expected_beats.pop_front();
          check_field("valid_res", e.valid_res, m_axis_tuser[0]);
          check_field("centered_sample", e.f.centered_sample, got.centered_sample);
          check_field("half_index", e.f.half_index, got.half_index);
          check_field("frame_number", e.f.frame_number, got.frame_number);
          check_field("last", e.last, m_axis_tlast);
          check_field("ready_bits", e.f.ready_bits, got.ready_bits);
          check_field("overflow_flag", e.f.overflow_flag, got.overflow_flag);
          check_field("dropped_count", e.f.dropped_count, got.dropped_count);
          check_field("write_position", e.f.write_position, got.write_position);
          check_field("last_raw_value", e.f.last_raw_value, got.last_raw_value);
          check_field("capturing", e.f.capturing, got.capturing);
          check_field("frame_samples_out", e.f.frame_samples_out, got.frame_samples_out);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_capture(s_axis_tuser, s_axis_tdata[11:0]);
      if (cfg_valid && cfg_ready) flen = cfg_data;
    end
  end

  // Driver: a beat stays on the bus until accepted; a new one is offered only after the
  // previous was taken, and then skipped at random according to the sender idle rate.
  // The receiver's tready is redrawn every cycle.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        drive_item    = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drive_item.act;
        s_axis_tdata  <= {4'b0000, drive_item.raw};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  function automatic logic [11:0] rand_raw();
    logic [11:0] corners [4] = '{12'h000, 12'hFFF, 12'h800, 12'h7FF};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
    return 12'($urandom_range(0, 4095));
  endfunction

  // Queue one input beat. Samples sent while capture is stopped are ignored by the block
  // and so are not counted toward the stimulus amount.
  task automatic push_item(input logic [1:0] act, input logic [11:0] raw);
    stim_item_t it;
    it.act = act;
    it.raw = raw;
    pending_items.push_back(it);
    if (act != ACT_SAMPLE || gen_running) item_count++;
    if (act == ACT_START) gen_running = 1'b1;
    if (act == ACT_STOP) gen_running = 1'b0;
  endtask

  // Mostly well-formed capture runs (start if needed, up to enough samples to fill both halves,
  // then acquires), with some stray starts, stops and random noise mixed in.
  task automatic gen_burst(input int unsigned len);
    int unsigned r, n, k;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      push_item(ACT_START, rand_raw());
    end else if (r < 10) begin
      push_item(ACT_STOP, rand_raw());
    end else if (r < 20) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) push_item(2'($urandom_range(0, 3)), rand_raw());
    end else begin
      if (!gen_running) push_item(ACT_START, rand_raw());
      n = $urandom_range(1, 2 * len + 1);
      for (k = 0; k < n; k++) push_item(ACT_SAMPLE, rand_raw());
      n = $urandom_range(0, 3);
      for (k = 0; k < n; k++) push_item(ACT_ACQUIRE, rand_raw());
    end
  endtask

  // Wait until every queued beat is accepted and every expected beat has come back.
  // Checked at the falling edge, where neither queue is being updated by the monitor.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_beats.size() != 0);
  endtask

  task automatic write_frame_length(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [LEN_W-1:0] len_plan [9];
    int unsigned      p, target, len;

    len_plan = '{7'd0, 7'd127, 7'd5, 7'd64, 7'd1, 7'd2, 7'd33,
                 7'($urandom_range(1, 64)), 7'd9};

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 29;
    snk_idle_pct = 58;
    write_frame_length(7'd4);

    // Directed part with four samples per half. Before any start: acquire finds nothing,
    // a sample is ignored, stop is harmless.
    push_item(ACT_ACQUIRE, 12'h000);
    push_item(ACT_SAMPLE, 12'hFFF);
    push_item(ACT_STOP, 12'h000);
    push_item(ACT_START, 12'hFFF);
    // Fill half zero with the sample extremes, then half one, then half zero again while
    // it is still unread, which overflows and drops a frame.
    push_item(ACT_SAMPLE, 12'h000);
    push_item(ACT_SAMPLE, 12'hFFF);
    push_item(ACT_SAMPLE, 12'h800);
    push_item(ACT_SAMPLE, 12'h7FF);
    push_item(ACT_SAMPLE, 12'h001);
    push_item(ACT_SAMPLE, 12'hAAA);
    push_item(ACT_SAMPLE, 12'h555);
    push_item(ACT_SAMPLE, 12'h801);
    push_item(ACT_SAMPLE, 12'h123);
    push_item(ACT_SAMPLE, 12'hFFE);
    push_item(ACT_SAMPLE, 12'h7FE);
    push_item(ACT_SAMPLE, 12'hC00);
    // Stopped: the sample is ignored but both ready halves are still served, the older
    // stamp (half one) first, then half zero, then nothing is left.
    push_item(ACT_STOP, 12'h000);
    push_item(ACT_SAMPLE, 12'h3C3);
    push_item(ACT_ACQUIRE, 12'h000);
    push_item(ACT_ACQUIRE, 12'hFFF);
    push_item(ACT_ACQUIRE, 12'h000);
    wait_drained();

    // Random part: nine phases, each with its own frame length. The length is changed
    // without a restart, so the write position can land past the shrunk ring.
    for (p = 0; p < 9; p++) begin
      if (p < 3) begin
        src_idle_pct = 29;
        snk_idle_pct = 58;
      end else if (p < 6) begin
        src_idle_pct = 58;
        snk_idle_pct = 29;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // A start clears the ring after its beat is taken; let that finish first.
      repeat (140) @(negedge clk);
      write_frame_length(len_plan[p]);
      len        = eff_len(len_plan[p]);
      item_count = 0;
      target     = (p == 4) ? 9 : 18;
      while (item_count < target) gen_burst(len);
      if (p == 4) begin
        // Hold the sender until everything so far has come back, then carry on.
        wait_drained();
        item_count = 0;
        while (item_count < target) gen_burst(len);
      end
      wait_drained();
    end

    repeat (200) @(negedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
